[rtl/rtpd_pkg.sv]
// shared types and constants for the rtp h264 depacketizer
// no dependencies
`default_nettype none

package rtpd_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [4:0] TYPE_STAPA = 5'd24;
  localparam logic [4:0] TYPE_FUA   = 5'd28;
  localparam logic [4:0] TYPE_SINGLE_LO = 5'd1;
  localparam logic [4:0] TYPE_SINGLE_HI = 5'd23;
  localparam int unsigned FU_START_BIT = 7;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  typedef enum logic [1:0] {
    CMD_BYTE       = 2'd0,
    CMD_START_BYTE = 2'd1,
    CMD_START      = 2'd2,
    CMD_ERROR      = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/rtpd_front.sv]
// front end: accepts payload bytes, tracks packet state, issues emit commands
// depends on rtpd_pkg
`default_nettype none

module rtpd_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 accept,
  input  wire  [7:0]          in_byte,
  input  wire                 first_of_payload,
  input  wire  [15:0]         payload_len,
  output logic                cmd_valid,
  output rtpd_pkg::cmd_t      cmd
);
  import rtpd_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_SINGLE   = 7'b0000010,
    PH_STAP_HI  = 7'b0000100,
    PH_STAP_LO  = 7'b0001000,
    PH_STAP_NAL = 7'b0010000,
    PH_FU_HDR   = 7'b0100000,
    PH_FU_DATA  = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] payload_left_r, payload_left_nxt;
  logic [15:0] unit_left_r, unit_left_nxt;
  logic [7:0]  size_hi_r, size_hi_nxt;
  logic [2:0]  top_r, top_nxt;

  logic [4:0]  hdr_type;
  logic [15:0] pl_dec;
  logic [15:0] size;
  logic [15:0] unit_dec;

  always_comb begin
    phase_nxt        = phase_r;
    payload_left_nxt = payload_left_r;
    unit_left_nxt    = unit_left_r;
    size_hi_nxt      = size_hi_r;
    top_nxt          = top_r;
    cmd_valid        = 1'b0;
    cmd.kind         = CMD_BYTE;
    cmd.data         = in_byte;
    hdr_type         = in_byte[4:0];
    pl_dec           = payload_left_r - 16'd1;
    size             = {size_hi_r, in_byte};
    unit_dec         = (unit_left_r != 16'd0) ? unit_left_r - 16'd1 : 16'd0;

    if (accept) begin
      if (first_of_payload) begin
        payload_left_nxt = (payload_len != 16'd0) ? payload_len - 16'd1 : 16'd0;
        unit_left_nxt    = 16'd0;
        if (hdr_type >= TYPE_SINGLE_LO && hdr_type <= TYPE_SINGLE_HI) begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_START_BYTE;
          phase_nxt = PH_SINGLE;
        end else if (hdr_type == TYPE_STAPA) begin
          phase_nxt = PH_STAP_HI;
        end else if (hdr_type == TYPE_FUA) begin
          top_nxt   = in_byte[7:5];
          phase_nxt = PH_FU_HDR;
        end else begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_ERROR;
          cmd.data  = SC_ZERO;
          phase_nxt = PH_IDLE;
        end
      end else if (phase_r != PH_IDLE) begin
        if (payload_left_r == 16'd0) begin
          phase_nxt = PH_IDLE;
        end else begin
          payload_left_nxt = pl_dec;
          case (phase_r)
            PH_SINGLE, PH_FU_DATA: begin
              cmd_valid = 1'b1;
            end
            PH_STAP_HI: begin
              size_hi_nxt = in_byte;
              phase_nxt   = PH_STAP_LO;
            end
            PH_STAP_LO: begin
              if (size <= pl_dec) begin
                cmd_valid     = 1'b1;
                cmd.kind      = CMD_START;
                unit_left_nxt = size;
                if (size == 16'd0) begin
                  phase_nxt = (pl_dec > 16'd2) ? PH_STAP_HI : PH_IDLE;
                end else begin
                  phase_nxt = PH_STAP_NAL;
                end
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_STAP_NAL: begin
              cmd_valid     = 1'b1;
              unit_left_nxt = unit_dec;
              if (unit_dec == 16'd0) begin
                phase_nxt = (pl_dec > 16'd2) ? PH_STAP_HI : PH_IDLE;
              end
            end
            PH_FU_HDR: begin
              if (in_byte[FU_START_BIT]) begin
                cmd_valid = 1'b1;
                cmd.kind  = CMD_START_BYTE;
                cmd.data  = {top_r, in_byte[4:0]};
              end
              phase_nxt = PH_FU_DATA;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
      if (payload_left_nxt == 16'd0) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      payload_left_r <= 16'd0;
      unit_left_r    <= 16'd0;
      size_hi_r      <= 8'd0;
      top_r          <= 3'd0;
    end else begin
      phase_r        <= phase_nxt;
      payload_left_r <= payload_left_nxt;
      unit_left_r    <= unit_left_nxt;
      size_hi_r      <= size_hi_nxt;
      top_r          <= top_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/rtpd_fifo.sv]
// short command queue between front and back end
// depends on rtpd_pkg
`default_nettype none

module rtpd_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  rtpd_pkg::cmd_t      push_cmd,
  input  wire                 pop,
  output rtpd_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);
  import rtpd_pkg::*;

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == QDEPTH[QAW:0]);
  assign head    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/rtpd_back.sv]
// back end: expands queued commands into annex b output bytes
// depends on rtpd_pkg
`default_nettype none

module rtpd_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rtpd_pkg::cmd_t      head,
  input  wire                 empty,
  output logic                pop,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);
  import rtpd_pkg::*;

  cmd_t       cmd_r, cmd_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       err_r, err_nxt;
  logic       last_r, last_nxt;

  cmd_t       cur;
  logic [1:0] idx;
  logic       have;
  logic       load;
  logic [7:0] res_data;
  logic       res_err;
  logic       res_last;

  always_comb begin
    cur      = busy_r ? cmd_r : head;
    idx      = busy_r ? cnt_r : 2'd0;
    have     = busy_r || !empty;
    load     = have && (!valid_r || out_tready);
    res_data = SC_ZERO;
    res_err  = 1'b0;
    res_last = 1'b0;
    case (cur.kind)
      CMD_BYTE: begin
        res_data = cur.data;
        res_last = 1'b1;
      end
      CMD_START_BYTE: begin
        if (idx == 2'd2) begin
          res_data = SC_ONE;
        end else if (idx == 2'd3) begin
          res_data = cur.data;
          res_last = 1'b1;
        end
      end
      CMD_START: begin
        if (idx == 2'd2) begin
          res_data = SC_ONE;
          res_last = 1'b1;
        end
      end
      CMD_ERROR: begin
        res_err  = 1'b1;
        res_last = 1'b1;
      end
      default: begin
        res_last = 1'b1;
      end
    endcase

    pop       = load && !busy_r;
    cmd_nxt   = cmd_r;
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r && !out_tready;
    data_nxt  = data_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res_data;
      err_nxt   = res_err;
      last_nxt  = res_last;
      if (res_last) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        cmd_nxt  = cur;
        cnt_nxt  = idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    data_r <= data_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = err_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

[rtl/rtp_h264_depacketizer.sv]
// rtp h264 payload to annex b byte stream: one payload byte accepted per cycle
// accepted bytes pass the command queue, then the output register; a start code
// burst gives up to four results from one input, one per cycle unless stalled
// throughput: one input per cycle while the four-entry command queue has room
// reset: synchronous active-low rst_n clears packet state, queue and output valid
// depends on rtpd_pkg, rtpd_front, rtpd_fifo, rtpd_back
`default_nettype none

module rtp_h264_depacketizer (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // in_byte[7:0], payload_len[23:8]
  input  wire         in_tuser,   // first_of_payload
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tuser,  // is_error
  output logic        out_tlast   // last_of_run
);
  import rtpd_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t head;
  logic empty;
  logic full;
  logic pop;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  rtpd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_byte          (in_tdata[7:0]),
    .first_of_payload (in_tuser),
    .payload_len      (in_tdata[23:8]),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd)
  );

  rtpd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_valid),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  rtpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/rtpd_checker.sv]
// port-level checks for rtp_h264_depacketizer, attached by bind
// depends on rtp_h264_depacketizer
`default_nettype none

module rtpd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [7:0]  out_tdata,
  input wire        out_tuser,
  input wire        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output changed");

  // error result is a lone zero byte
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h00 && out_tlast)
    else $error("malformed error result");

  // a started run continues without a gap
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a result run");

  // input backpressure only while output holds a result
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with idle output");

  // nothing valid right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind rtp_h264_depacketizer rtpd_checker u_rtpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for rtp_h264_depacketizer: payload bytes in, annex b bytes out
// predicts single nal, stap-a, fu-a and error results from its own model of the unpacking
// depends on rtpd_pkg and the rtp_h264_depacketizer rtl
`timescale 1ns / 100ps

module testbench;
  import rtpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 55;

  localparam logic [4:0] TYPE_UNSPEC  = 5'd0;
  localparam logic [4:0] TYPE_IDR     = 5'd5;
  localparam logic [4:0] TYPE_STAPB   = 5'd25;
  localparam logic [4:0] TYPE_MTAP16  = 5'd26;
  localparam logic [4:0] TYPE_MTAP24  = 5'd27;
  localparam logic [4:0] TYPE_FUB     = 5'd29;
  localparam logic [4:0] TYPE_RSVD30  = 5'd30;
  localparam logic [4:0] TYPE_RSVD31  = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SINGLE, ST_STAP_HI, ST_STAP_LO, ST_STAP_NAL, ST_FU_HDR, ST_FU_DATA
  } unpack_state_t;

  typedef struct {
    logic [7:0] data;
    logic       err;
    logic       last;
  } annexb_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // in_byte[7:0], payload_len[23:8]
  logic        in_tuser = 1'b0; // first_of_payload
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // out_byte[7:0]
  logic        out_tuser;       // is_error
  logic        out_tlast;       // last_of_run

  // predictor state
  unpack_state_t st = ST_IDLE;
  logic [15:0]   pay_left = '0;
  logic [15:0]   nal_left = '0;
  logic [7:0]    size_msb = '0;
  logic [2:0]    fu_bits = '0;

  annexb_t annexb_q[$];
  annexb_t step_res[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned error_results = 0;
  int unsigned live_items = 0;
  int unsigned payloads = 0;
  int unsigned in_stalls = 0;
  int unsigned send_gap_max = 17;
  int unsigned recv_gap_max = 17;
  int unsigned hold_off = 0;

  rtp_h264_depacketizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] nal_hdr(input logic [2:0] top, input logic [4:0] typ);
    return {top, typ};
  endfunction

  function automatic int unsigned draw_gap(input int unsigned max);
    if (max == 0 || $urandom_range(1, 0) == 1) return 0;
    return $urandom_range(max, 1);
  endfunction

  function automatic void add_result(input logic [7:0] data, input logic err);
    annexb_t r;
    r.data = data;
    r.err  = err;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void add_start_code();
    add_result(SC_ZERO, 1'b0);
    add_result(SC_ZERO, 1'b0);
    add_result(SC_ONE, 1'b0);
  endfunction

  // annex b bytes caused by one accepted payload byte
  function automatic void unpack_byte(input logic [7:0] b, input logic first,
                                      input logic [15:0] len);
    logic [4:0]  typ;
    logic [15:0] size;
    typ = b[4:0];
    step_res = {};
    if (first) begin
      pay_left = (len == 16'd0) ? 16'd0 : len - 16'd1;
      nal_left = '0;
      if (typ >= TYPE_SINGLE_LO && typ <= TYPE_SINGLE_HI) begin
        add_start_code();
        add_result(b, 1'b0);
        st = ST_SINGLE;
      end else if (typ == TYPE_STAPA) begin
        st = ST_STAP_HI;
      end else if (typ == TYPE_FUA) begin
        fu_bits = b[7:5];
        st = ST_FU_HDR;
      end else begin
        add_result(8'h00, 1'b1);
        st = ST_IDLE;
      end
    end else if (st != ST_IDLE) begin
      if (pay_left == 16'd0) begin
        st = ST_IDLE;
      end else begin
        pay_left = pay_left - 16'd1;
        case (st)
          ST_SINGLE, ST_FU_DATA: begin
            add_result(b, 1'b0);
          end
          ST_STAP_HI: begin
            size_msb = b;
            st = ST_STAP_LO;
          end
          ST_STAP_LO: begin
            size = {size_msb, b};
            if (size <= pay_left) begin
              add_start_code();
              nal_left = size;
              if (size == 16'd0) st = (pay_left > 16'd2) ? ST_STAP_HI : ST_IDLE;
              else st = ST_STAP_NAL;
            end else begin
              st = ST_IDLE;
            end
          end
          ST_STAP_NAL: begin
            add_result(b, 1'b0);
            if (nal_left > 16'd0) nal_left = nal_left - 16'd1;
            if (nal_left == 16'd0) st = (pay_left > 16'd2) ? ST_STAP_HI : ST_IDLE;
          end
          ST_FU_HDR: begin
            if (b[FU_START_BIT]) begin
              add_start_code();
              add_result({fu_bits, b[4:0]}, 1'b0);
            end
            st = ST_FU_DATA;
          end
          default: begin
            st = ST_IDLE;
          end
        endcase
      end
    end
    if (pay_left == 16'd0) st = ST_IDLE;
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) annexb_q.push_back(step_res[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // one request on the input side; valid stays up for a back-to-back follower
  task automatic send_item(input logic [7:0] b, input logic first, input logic [15:0] len);
    int unsigned gap;
    gap = draw_gap(send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, b};
    in_tuser  <= first;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (first || st != ST_IDLE) live_items++;
    unpack_byte(b, first, len);
  endtask

  task automatic send_payload(input byte_q_t pl, input logic [15:0] len);
    foreach (pl[i]) send_item(pl[i], i == 0, (i == 0) ? len : 16'($urandom));
    payloads++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (annexb_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls per result, plus an occasional long hold-off
  initial begin
    int unsigned gap;
    forever begin
      gap = draw_gap(recv_gap_max);
      if (hold_off > 0) begin
        gap = hold_off;
        hold_off = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    annexb_t want;
    if (rst_n && in_tvalid && !in_tready) in_stalls++;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (out_tuser) error_results++;
      if (annexb_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h err %0b last %0b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        want = annexb_q.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("byte %02h, expected %02h", out_tdata, want.data));
        if (out_tuser !== want.err)
          report_mismatch($sformatf("error flag %0b, expected %0b", out_tuser, want.err));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last flag %0b, expected %0b", out_tlast, want.last));
      end
    end
  end

  task automatic test_single_nal();
    send_payload({nal_hdr(3'd3, TYPE_SINGLE_LO), 8'h00, 8'hff}, 16'd3);
    // zero length acts as header only
    send_payload({nal_hdr(3'd7, TYPE_SINGLE_HI)}, 16'd0);
    // stray byte while idle
    send_item(8'h33, 1'b0, 16'hffff);
    wait_drained();
  endtask

  task automatic test_bad_types();
    send_payload({nal_hdr(3'd0, TYPE_UNSPEC), 8'h11}, 16'd2);
    send_payload({nal_hdr(3'd7, TYPE_RSVD31)}, 16'd1);
    wait_drained();
  endtask

  task automatic test_stap_a();
    // one unit, a zero size unit, then a two byte tail that is dropped
    send_payload({nal_hdr(3'd3, TYPE_STAPA), 8'h00, 8'h01, 8'haa, 8'h00, 8'h00,
                  8'hde, 8'had}, 16'd8);
    // unit size past the end of the payload
    send_payload({nal_hdr(3'd0, TYPE_STAPA), 8'h00, 8'h05}, 16'd3);
    wait_drained();
  endtask

  task automatic test_fu_a();
    send_payload({nal_hdr(3'd3, TYPE_FUA), {3'b100, TYPE_IDR}, 8'h11}, 16'd3);
    // end fragment carries no start code and no header
    send_payload({nal_hdr(3'd2, TYPE_FUA), {3'b010, TYPE_IDR}}, 16'd2);
    wait_drained();
  endtask

  task automatic test_broken_payloads();
    // long payload abandoned by a new one, which is a truncated fu-a
    send_payload({nal_hdr(3'd3, TYPE_SINGLE_HI), 8'h01}, 16'hffff);
    send_payload({nal_hdr(3'd2, TYPE_FUA)}, 16'd1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    byte_q_t pl;
    pl = {nal_hdr(3'd2, TYPE_SINGLE_LO)};
    repeat (23) pl.push_back(8'($urandom));
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_off = 120;
    send_payload(pl, 16'(pl.size()));
    wait_drained();
    send_gap_max = 17;
    recv_gap_max = 17;
  endtask

  task automatic send_random_payload();
    byte_q_t     pl;
    logic [15:0] len;
    logic [4:0]  typ;
    int unsigned sz;
    pl = {};
    typ = TYPE_UNSPEC;
    case ($urandom_range(9, 0))
      0, 1, 2: begin
        pl.push_back(nal_hdr(3'($urandom),
                             5'($urandom_range(TYPE_SINGLE_HI, TYPE_SINGLE_LO))));
        repeat ($urandom_range(6, 0)) pl.push_back(8'($urandom));
      end
      3, 4, 5: begin
        pl.push_back(nal_hdr(3'($urandom), TYPE_STAPA));
        repeat ($urandom_range(3, 1)) begin
          sz = $urandom_range(5, 0);
          pl.push_back(8'h00);
          pl.push_back(8'(sz));
          repeat (sz) pl.push_back(8'($urandom));
        end
        repeat ($urandom_range(2, 0)) pl.push_back(8'($urandom));
      end
      6, 7: begin
        pl.push_back(nal_hdr(3'($urandom), TYPE_FUA));
        pl.push_back(8'($urandom));
        repeat ($urandom_range(5, 0)) pl.push_back(8'($urandom));
      end
      8: begin
        case ($urandom_range(6, 0))
          0: typ = TYPE_UNSPEC;
          1: typ = TYPE_STAPB;
          2: typ = TYPE_MTAP16;
          3: typ = TYPE_MTAP24;
          4: typ = TYPE_FUB;
          5: typ = TYPE_RSVD30;
          default: typ = TYPE_RSVD31;
        endcase
        pl.push_back(nal_hdr(3'($urandom), typ));
        repeat ($urandom_range(3, 0)) pl.push_back(8'($urandom));
      end
      default: begin
        if ($urandom_range(1, 0) == 1) begin
          repeat ($urandom_range(3, 1)) send_item(8'($urandom), 1'b0, 16'($urandom));
          return;
        end
        repeat ($urandom_range(8, 1)) pl.push_back(8'($urandom));
      end
    endcase
    len = 16'(pl.size());
    if ($urandom_range(7, 0) == 0) len = 16'($urandom_range(pl.size() + 2, 0));
    else if ($urandom_range(31, 0) == 0) len = 16'($urandom);
    send_payload(pl, len);
  endtask

  task automatic test_random_payloads();
    int unsigned target;
    int unsigned idle_max;
    target = live_items + RANDOM_BYTES;
    while (live_items < target) begin
      idle_max = ($urandom_range(3, 0) == 0) ? 0 : 17;
      send_gap_max = idle_max;
      recv_gap_max = idle_max;
      send_random_payload();
      if ($urandom_range(9, 0) == 0) wait_drained();
    end
    send_gap_max = 17;
    recv_gap_max = 17;
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_single_nal();
    test_bad_types();
    test_stap_a();
    test_fu_a();
    test_broken_payloads();
    test_backpressure();
    test_random_payloads();
    wait_drained();
    repeat (24) @(posedge clk);
    $display("covered: %0d payloads, %0d live payload bytes, %0d input stall cycles",
             payloads, live_items, in_stalls);
    $display("checked: %0d annex b results, %0d of them error markers, %0d mismatches",
             results_checked, error_results, mismatches);
    if (mismatches == 0 && annexb_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rtpd_pkg.sv
rtl/rtpd_front.sv
rtl/rtpd_fifo.sv
rtl/rtpd_back.sv
rtl/rtp_h264_depacketizer.sv
rtl/rtpd_checker.sv
dv/testbench.sv
